// ===== design/bcpk_pkg.sv =====
// Shared types, constants and the candidate preference function of the best-candidate table.
package bcpk_pkg;

    localparam int TABLE_SIZE = 32;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int CNT_W      = $clog2(TABLE_SIZE + 1);
    localparam int KEY_W      = 31;
    localparam int VAL_W      = 32;
    localparam int ENTRY_W    = 2 * KEY_W + 2 * VAL_W + 1;
    localparam int TDATA_W    = ((ENTRY_W + 7) / 8) * 8;
    localparam int TUSER_W    = 2;

    typedef struct packed {
        logic [VAL_W-1:0] fitness;
        logic             energy_ok;
        logic [VAL_W-1:0] energy;
        logic [KEY_W-1:0] match_key;
        logic [KEY_W-1:0] query_key;
    } entry_t;

    typedef enum logic [TUSER_W-1:0] {
        STATUS_SELECTED = 2'd0,
        STATUS_DROPPED  = 2'd1,
        STATUS_EMPTY    = 2'd2
    } status_t;

    typedef enum logic {
        OUT_ENTRY,
        OUT_SINGLE
    } out_sel_t;

    typedef struct packed {
        logic     load_item;
        logic     idx_clear;
        logic     idx_inc;
        logic     rd_en;
        logic     wr_hit;
        logic     wr_new;
        logic     cnt_clear;
        logic     out_load;
        out_sel_t out_sel;
    } ctl_cmd_t;

    typedef struct packed {
        logic kind_drain;
        logic cnt_zero;
        logic cnt_full;
        logic idx_last;
        logic key_hit;
        logic offer_wins;
        logic out_free;
    } dp_stat_t;

    function automatic logic prefer_offer(entry_t offer, entry_t stored);
        logic result;
        if (offer.energy_ok && stored.energy_ok && (offer.energy != stored.energy))
        begin
            result = $signed(offer.energy) > $signed(stored.energy);
        end
        else if (offer.fitness != stored.fitness)
        begin
            result = offer.fitness < stored.fitness;
        end
        else
        begin
            result = offer.match_key < stored.match_key;
        end
        return result;
    endfunction

endpackage

// ===== design/bcpk_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bcpk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/bcpk_datapath.sv =====
// Datapath: item register, slot RAM, fill count, scan index and output register.
module bcpk_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  bcpk_pkg::ctl_cmd_t        cmd,
    output bcpk_pkg::dp_stat_t        stat,
    input  logic [bcpk_pkg::TDATA_W-1:0] s_tdata,
    input  logic                      s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [bcpk_pkg::TDATA_W-1:0] m_tdata,
    output logic [bcpk_pkg::TUSER_W-1:0] m_tuser,
    output logic                      m_tlast
);
    import bcpk_pkg::*;

    logic             kind_reg;
    entry_t           item_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    entry_t           out_entry_reg;
    status_t          out_status_reg;
    logic             out_last_reg;

    entry_t           rd_entry;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;

    assign wr_en   = cmd.wr_hit || cmd.wr_new;
    assign wr_addr = cmd.wr_hit ? idx_reg : cnt_reg[IDX_W-1:0];

    bcpk_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SIZE)
    ) u_slots (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (item_reg),
        .rd_en   (cmd.rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_entry)
    );

    assign stat.kind_drain = kind_reg;
    assign stat.cnt_zero   = (cnt_reg == '0);
    assign stat.cnt_full   = (cnt_reg == CNT_W'(TABLE_SIZE));
    assign stat.idx_last   = ((CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg);
    assign stat.key_hit    = (rd_entry.query_key == item_reg.query_key);
    assign stat.offer_wins = prefer_offer(item_reg, rd_entry);
    assign stat.out_free   = !out_valid_reg || m_tready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.cnt_clear)
        begin
            cnt_next = '0;
        end
        else if (cmd.wr_new)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end

        idx_next = idx_reg;
        if (cmd.idx_clear)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end

        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            kind_reg <= s_tuser;
            item_reg <= s_tdata[ENTRY_W-1:0];
        end
        if (cmd.out_load)
        begin
            unique case (cmd.out_sel)
                OUT_ENTRY:
                begin
                    out_entry_reg  <= rd_entry;
                    out_status_reg <= STATUS_SELECTED;
                    out_last_reg   <= stat.idx_last;
                end
                OUT_SINGLE:
                begin
                    out_entry_reg  <= kind_reg ? '0 : item_reg;
                    out_status_reg <= kind_reg ? STATUS_EMPTY : STATUS_DROPPED;
                    out_last_reg   <= 1'b1;
                end
                default:
                begin
                    out_entry_reg  <= rd_entry;
                    out_status_reg <= STATUS_SELECTED;
                    out_last_reg   <= stat.idx_last;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(TDATA_W - ENTRY_W){1'b0}}, out_entry_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== design/bcpk_ctrl.sv =====
// Controller: sequences lookup, update, insert, drain and single results.
module bcpk_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  bcpk_pkg::dp_stat_t stat,
    output bcpk_pkg::ctl_cmd_t cmd
);
    import bcpk_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_READ,
        ST_CMP,
        ST_EMIT,
        ST_SINGLE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.out_sel = OUT_ENTRY;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_item = 1'b1;
                    cmd.idx_clear = 1'b1;
                    state_next    = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (stat.cnt_zero)
                begin
                    if (stat.kind_drain)
                    begin
                        state_next = ST_SINGLE;
                    end
                    else
                    begin
                        cmd.wr_new = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = stat.kind_drain ? ST_EMIT : ST_CMP;
            end
            ST_CMP:
            begin
                if (stat.key_hit)
                begin
                    cmd.wr_hit = stat.offer_wins;
                    state_next = ST_IDLE;
                end
                else if (stat.idx_last)
                begin
                    if (stat.cnt_full)
                    begin
                        state_next = ST_SINGLE;
                    end
                    else
                    begin
                        cmd.wr_new = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (stat.idx_last)
                    begin
                        cmd.cnt_clear = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_READ;
                    end
                end
            end
            ST_SINGLE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OUT_SINGLE;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/best_candidate_per_key_table.sv =====
// Top level of the best-candidate-per-key table.
//
// Channel  Dir  Handshake            Content
// s_*      in   s_tvalid/s_tready    offer or drain item, kind in s_tuser
// m_*      out  m_tvalid/m_tready    table entry or marker, status in m_tuser, m_tlast
//
// An offer scans the slots up to a key hit or the fill count; a new key on an empty table
// is written without a scan, and a dropped offer then emits its own result.
// Scan is one RAM read and one key compare per slot.
// A drain reads and emits each of its n entries in turn, or one empty marker on an empty table.
// Reset clears the fill count, scan index, controller and output valid; the slot RAM needs no clearing.
// A stalled output holds the scan; the next item is taken while the last result waits.
module best_candidate_per_key_table (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // query_key[30:0], match_key[61:31], energy[93:62], energy_finite[94], fitness[126:95]
    input  logic [bcpk_pkg::TDATA_W-1:0]  s_tdata,
    // kind
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_query_key[30:0], out_match_key[61:31], out_energy[93:62],
    // out_energy_finite[94], out_fitness[126:95]
    output logic [bcpk_pkg::TDATA_W-1:0]  m_tdata,
    // status
    output logic [bcpk_pkg::TUSER_W-1:0]  m_tuser,
    output logic                          m_tlast
);
    import bcpk_pkg::*;

    ctl_cmd_t cmd;
    dp_stat_t stat;

    bcpk_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bcpk_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
